@@ hw/rtl/vmpu_pkg.sv @@
// Shared types, constants and tables of the velocity motion pose update unit.
// Depends on nothing; every other file imports it.
`default_nettype none

package vmpu_pkg;

  localparam int POS_BITS_DEF   = 32;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int MUL_W          = 64;
  localparam int DIV_W          = 64;
  localparam int GAIN_W         = 16;

  localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd655;
  localparam logic [63:0]       TURN_K       = 64'd716770142;
  localparam logic [63:0]       TWO_PI_Q30   = 64'd6746518852;
  localparam logic [31:0]       ONE_Q30      = 32'h4000_0000;
  localparam logic [63:0]       USEC_PER_SEC = 64'd1000000;
  localparam logic [2:0]        HORNER_LAST  = 3'd4;

  typedef enum logic {
    OP_MOTION = 1'b0,
    OP_ZERO   = 1'b1
  } item_op_t;

  typedef enum logic {
    CFG_GAIN_SPEED = 1'b0,
    CFG_GAIN_TURN  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    item_op_t           operation;
    logic signed [15:0] linear_speed;
    logic signed [15:0] turn_rate;
    logic [31:0]        timestamp_us;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [15:0]        pose_heading;
    logic               straight_move;
  } out_item_t;

  typedef struct packed {
    logic mul_start;
    logic div_start;
  } unit_req_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
  } unit_ack_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DRV,
    ST_DRW,
    ST_WDT,
    ST_PW,
    ST_NUM,
    ST_PGH,
    ST_PGL,
    ST_SC_X,
    ST_SC_X2,
    ST_SC_D,
    ST_SC_M,
    ST_SC_S0,
    ST_SC_CF,
    ST_DST,
    ST_DDV,
    ST_SX,
    ST_SY,
    ST_AXM,
    ST_AXD,
    ST_AYM,
    ST_AYD,
    ST_UPD
  } seq_state_t;

  // Horner denominators of the sine and cosine series, innermost first.
  function automatic logic [63:0] horner_den(input logic cos_ph, input logic [2:0] k);
    logic [63:0] d;
    d = 64'd1;
    case (k)
      3'd0:    d = cos_ph ? 64'd132 : 64'd110;
      3'd1:    d = cos_ph ? 64'd90  : 64'd72;
      3'd2:    d = cos_ph ? 64'd56  : 64'd42;
      3'd3:    d = cos_ph ? 64'd30  : 64'd20;
      3'd4:    d = cos_ph ? 64'd12  : 64'd6;
      default: d = 64'd1;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/vmpu_mul.sv @@
// Shift-add multiplier, one multiplier bit per cycle, full double-width product.
// Depends on vmpu_pkg.
`default_nettype none

module vmpu_mul import vmpu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [MUL_W-1:0]     a,
  input  logic [MUL_W-1:0]     b,
  output logic                 done,
  output logic [2*MUL_W-1:0]   p
);

  localparam int CW = $clog2(MUL_W);

  logic [MUL_W-1:0] hi, lo, mcand;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [MUL_W:0]   sum;

  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : {(MUL_W+1){1'b0}});
  assign p   = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(MUL_W-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi    <= '0;
      lo    <= b;
      mcand <= a;
    end else if (busy) begin
      hi <= sum[MUL_W:1];
      lo <= {sum[0], lo[MUL_W-1:1]};
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/vmpu_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on vmpu_pkg.
`default_nettype none

module vmpu_div import vmpu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] n,
  input  logic [DIV_W-1:0] d,
  output logic             done,
  output logic [DIV_W-1:0] q
);

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W-1:0] rem, quo, dsr;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DIV_W:0]   sh;
  logic [DIV_W+1:0] trial;

  assign sh    = {rem, quo[DIV_W-1]};
  assign trial = {1'b0, sh} - {2'b00, dsr};
  assign q     = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_W-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= n;
      dsr <= d;
    end else if (busy) begin
      rem <= trial[DIV_W+1] ? sh[DIV_W-1:0] : trial[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], ~trial[DIV_W+1]};
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/vmpu_seq.sv @@
// Sequencer and datapath registers: pose state, phase terms, sine/cosine series
// and the arc or straight move, driving the shared multiplier and divider.
// Depends on vmpu_pkg.
`default_nettype none

module vmpu_seq import vmpu_pkg::*; #(
  parameter int POS_BITS   = POS_BITS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic [GAIN_W-1:0]    gain_speed,
  input  logic [GAIN_W-1:0]    gain_turn,
  output unit_req_t            req,
  input  unit_ack_t            ack,
  output logic [MUL_W-1:0]     mul_a,
  output logic [MUL_W-1:0]     mul_b,
  input  logic [2*MUL_W-1:0]   mul_p,
  output logic [DIV_W-1:0]     div_n,
  output logic [DIV_W-1:0]     div_d,
  input  logic [DIV_W-1:0]     div_q
);

  localparam logic signed [65:0] POS_MAX = (66'sd1 <<< (POS_BITS-1)) - 66'sd1;
  localparam logic signed [65:0] POS_MIN = -(66'sd1 <<< (POS_BITS-1));
  localparam logic [63:0]        HALF_LSB = 64'd1 << (63-ANGLE_BITS);

  seq_state_t state, state_next, step_target;

  // pose state
  logic [POS_BITS-1:0]   pos_x, pos_y;
  logic [ANGLE_BITS-1:0] heading;
  logic [31:0]           last_time;

  // per-item registers
  item_op_t           op;
  logic signed [15:0] v, w;
  logic [31:0]        dt;
  logic [63:0]        acc, drift, pw, pg, ang;
  logic [63:0]        dx, dy;
  logic [31:0]        x, x2, t, tmp;
  logic signed [31:0] s_r, s0, c0, s1, c1;
  logic [2:0]         k;
  logic               cos_ph, call, launched;

  logic        uses_div, busy_state, step, load;
  logic [63:0] theta, th_sum, abs_acc;
  logic [2:0]  oct;
  logic [29:0] r;
  logic [16:0] abs_v, abs_w;
  logic [31:0] abs_c0, abs_s0;
  logic [32:0] ds_x, dc_y;
  logic signed [31:0] c_fin, sn_o, cs_o;
  logic signed [65:0] sum_x, sum_y;
  logic [POS_BITS-1:0]   new_x, new_y;
  logic [ANGLE_BITS-1:0] new_h;
  logic [63:0] px64, py64;
  logic [31:0] h32;

  assign theta   = {heading, {(64-ANGLE_BITS){1'b0}}};
  assign oct     = ang[63:61];
  assign r       = oct[0] ? (30'h2000_0000 - {1'b0, ang[60:32]}) : {1'b0, ang[60:32]};
  assign abs_v   = v[15] ? (17'd0 - {1'b1, v}) : {1'b0, v};
  assign abs_w   = w[15] ? (17'd0 - {1'b1, w}) : {1'b0, w};
  assign abs_c0  = c0[31] ? (32'd0 - c0) : c0;
  assign abs_s0  = s0[31] ? (32'd0 - s0) : s0;
  assign abs_acc = acc[63] ? (64'd0 - acc) : acc;
  assign ds_x    = {s1[31], s1} - {s0[31], s0};
  assign dc_y    = {c0[31], c0} - {c1[31], c1};
  assign c_fin   = ONE_Q30 - mul_p[62:31];

  assign uses_div   = (state == ST_SC_D) || (state == ST_DDV) ||
                      (state == ST_AXD) || (state == ST_AYD);
  assign busy_state = (state != ST_IDLE) && (state != ST_UPD);
  assign step       = busy_state && launched && (uses_div ? ack.div_done : ack.mul_done);
  assign in_stall   = (state != ST_IDLE);
  assign load       = (state == ST_UPD) && (!out_valid || !out_stall);

  assign req.mul_start = busy_state && !uses_div && !launched;
  assign req.div_start = busy_state && uses_div && !launched;

  // fold the first-octant values out to the full circle
  always_comb begin
    unique case (oct)
      3'd0: begin sn_o = s_r;            cs_o = c_fin;          end
      3'd1: begin sn_o = c_fin;          cs_o = s_r;            end
      3'd2: begin sn_o = c_fin;          cs_o = 32'sd0 - s_r;   end
      3'd3: begin sn_o = s_r;            cs_o = 32'sd0 - c_fin; end
      3'd4: begin sn_o = 32'sd0 - s_r;   cs_o = 32'sd0 - c_fin; end
      3'd5: begin sn_o = 32'sd0 - c_fin; cs_o = 32'sd0 - s_r;   end
      3'd6: begin sn_o = 32'sd0 - c_fin; cs_o = s_r;            end
      3'd7: begin sn_o = 32'sd0 - s_r;   cs_o = c_fin;          end
    endcase
  end

  // operand select for the shared units
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_n = '0;
    div_d = 64'd1;
    unique case (state)
      ST_DRV:   begin mul_a = {48'd0, gain_speed};  mul_b = {{48{v[15]}}, v};      end
      ST_DRW:   begin mul_a = {48'd0, gain_turn};   mul_b = {{48{w[15]}}, w};      end
      ST_WDT:   begin mul_a = {{48{w[15]}}, w};     mul_b = {32'd0, dt};           end
      ST_PW:    begin mul_a = acc;                  mul_b = TURN_K;                end
      ST_NUM:   begin mul_a = drift;                mul_b = {32'd0, dt};           end
      ST_PGH:   begin mul_a = 64'($signed(acc) >>> 8); mul_b = TURN_K;             end
      ST_PGL:   begin mul_a = {56'd0, acc[7:0]};    mul_b = TURN_K;                end
      ST_SC_X:  begin mul_a = {34'd0, r};           mul_b = TWO_PI_Q30;            end
      ST_SC_X2: begin mul_a = {32'd0, x};           mul_b = {32'd0, x};            end
      ST_SC_M:  begin mul_a = {32'd0, x2};          mul_b = {32'd0, t};            end
      ST_SC_S0: begin mul_a = {32'd0, x};           mul_b = {32'd0, t};            end
      ST_SC_CF: begin mul_a = {32'd0, x2};          mul_b = {32'd0, t};            end
      ST_DST:   begin mul_a = {47'd0, abs_v};       mul_b = {32'd0, dt};           end
      ST_SX:    begin mul_a = acc;                  mul_b = {32'd0, abs_c0};       end
      ST_SY:    begin mul_a = acc;                  mul_b = {32'd0, abs_s0};       end
      ST_AXM:   begin mul_a = {{48{v[15]}}, v};     mul_b = {{31{ds_x[32]}}, ds_x}; end
      ST_AYM:   begin mul_a = {{48{v[15]}}, v};     mul_b = {{31{dc_y[32]}}, dc_y}; end
      ST_SC_D:  begin
        div_n = (k == 3'd0) ? {32'd0, x2} : {32'd0, tmp};
        div_d = horner_den(cos_ph, k);
      end
      ST_DDV:   begin div_n = {acc[55:0], 8'd0};    div_d = USEC_PER_SEC;          end
      ST_AXD,
      ST_AYD:   begin div_n = abs_acc;              div_d = {37'd0, abs_w, 10'd0}; end
      default:  begin end
    endcase
  end

  // next state
  always_comb begin
    step_target = state;
    unique case (state)
      ST_DRV:   step_target = ST_DRW;
      ST_DRW:   step_target = ST_WDT;
      ST_WDT:   step_target = ST_PW;
      ST_PW:    step_target = ST_NUM;
      ST_NUM:   step_target = ST_PGH;
      ST_PGH:   step_target = ST_PGL;
      ST_PGL:   step_target = ST_SC_X;
      ST_SC_X:  step_target = ST_SC_X2;
      ST_SC_X2: step_target = ST_SC_D;
      ST_SC_D:  step_target = (k == HORNER_LAST) ? (cos_ph ? ST_SC_CF : ST_SC_S0) : ST_SC_M;
      ST_SC_M:  step_target = ST_SC_D;
      ST_SC_S0: step_target = ST_SC_D;
      ST_SC_CF: step_target = call ? ST_AXM : ((w == 16'sd0) ? ST_DST : ST_SC_X);
      ST_DST:   step_target = ST_DDV;
      ST_DDV:   step_target = ST_SX;
      ST_SX:    step_target = ST_SY;
      ST_SY:    step_target = ST_UPD;
      ST_AXM:   step_target = ST_AXD;
      ST_AXD:   step_target = ST_AYM;
      ST_AYM:   step_target = ST_AYD;
      ST_AYD:   step_target = ST_UPD;
      default:  step_target = state;
    endcase

    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) begin
        state_next = (in_data.operation == OP_ZERO) ? ST_UPD : ST_DRV;
      end
      ST_UPD: if (load) begin
        state_next = ST_IDLE;
      end
      default: if (step) begin
        state_next = step_target;
      end
    endcase
  end

  // saturated position and rounded heading; a zero request clears the position and keeps the heading
  always_comb begin
    sum_x  = $signed({{(66-POS_BITS){pos_x[POS_BITS-1]}}, pos_x}) + $signed({{2{dx[63]}}, dx});
    sum_y  = $signed({{(66-POS_BITS){pos_y[POS_BITS-1]}}, pos_y}) + $signed({{2{dy[63]}}, dy});
    th_sum = theta + pw + pg + HALF_LSB;
    if (op == OP_ZERO) begin
      new_x = '0;
      new_y = '0;
      new_h = heading;
    end else begin
      priority if (sum_x > POS_MAX) new_x = POS_MAX[POS_BITS-1:0];
      else if (sum_x < POS_MIN)     new_x = POS_MIN[POS_BITS-1:0];
      else                          new_x = sum_x[POS_BITS-1:0];
      priority if (sum_y > POS_MAX) new_y = POS_MAX[POS_BITS-1:0];
      else if (sum_y < POS_MIN)     new_y = POS_MIN[POS_BITS-1:0];
      else                          new_y = sum_y[POS_BITS-1:0];
      new_h = th_sum[63 -: ANGLE_BITS];
    end
    px64 = {{(64-POS_BITS){new_x[POS_BITS-1]}}, new_x};
    py64 = {{(64-POS_BITS){new_y[POS_BITS-1]}}, new_y};
    h32  = {{(32-ANGLE_BITS){1'b0}}, new_h};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launched  <= 1'b0;
      out_valid <= 1'b0;
      pos_x     <= '0;
      pos_y     <= '0;
      heading   <= '0;
      last_time <= '0;
    end else begin
      if (req.mul_start || req.div_start) begin
        launched <= 1'b1;
      end else if (step) begin
        launched <= 1'b0;
      end
      if (state == ST_IDLE && in_valid && in_data.operation == OP_MOTION) begin
        last_time <= in_data.timestamp_us;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
        pos_x     <= new_x;
        pos_y     <= new_y;
        heading   <= new_h;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op <= in_data.operation;
      v  <= in_data.linear_speed;
      w  <= in_data.turn_rate;
      dt <= in_data.timestamp_us - last_time;
    end
    if (step) begin
      unique case (state)
        ST_DRV:   acc   <= mul_p[63:0];
        ST_DRW:   drift <= 64'($signed((acc << 4) + mul_p[63:0]) >>> 8);
        ST_WDT:   acc   <= mul_p[63:0];
        ST_PW:    pw    <= mul_p[63:0];
        ST_NUM:   acc   <= mul_p[63:0];
        ST_PGH:   pg    <= mul_p[63:0];
        ST_PGL: begin
          pg   <= pg + {8'd0, mul_p[63:8]};
          ang  <= theta;
          call <= 1'b0;
        end
        ST_SC_X:  x <= mul_p[63:32];
        ST_SC_X2: begin
          x2     <= mul_p[61:30];
          k      <= 3'd0;
          cos_ph <= 1'b0;
        end
        ST_SC_D: begin
          t <= ONE_Q30 - div_q[31:0];
          if (k != HORNER_LAST) begin
            k <= k + 3'd1;
          end
        end
        ST_SC_M:  tmp <= mul_p[61:30];
        ST_SC_S0: begin
          s_r    <= mul_p[61:30];
          k      <= 3'd0;
          cos_ph <= 1'b1;
        end
        ST_SC_CF: begin
          if (call) begin
            s1 <= sn_o;
            c1 <= cs_o;
          end else begin
            s0   <= sn_o;
            c0   <= cs_o;
            ang  <= theta + pw;
            call <= 1'b1;
          end
        end
        ST_DST:   acc <= mul_p[63:0];
        ST_DDV:   acc <= div_q;
        ST_SX:    dx  <= (v[15] ^ c0[31]) ? (64'd0 - {28'd0, mul_p[65:30]})
                                          : {28'd0, mul_p[65:30]};
        ST_SY:    dy  <= (v[15] ^ s0[31]) ? (64'd0 - {28'd0, mul_p[65:30]})
                                          : {28'd0, mul_p[65:30]};
        ST_AXM:   acc <= mul_p[63:0];
        ST_AXD:   dx  <= (acc[63] ^ w[15]) ? (64'd0 - div_q) : div_q;
        ST_AYM:   acc <= mul_p[63:0];
        ST_AYD:   dy  <= (acc[63] ^ w[15]) ? (64'd0 - div_q) : div_q;
        default:  begin end
      endcase
    end
    if (load) begin
      out_data.pose_x        <= px64[31:0];
      out_data.pose_y        <= py64[31:0];
      out_data.pose_heading  <= h32[15:0];
      out_data.straight_move <= (op == OP_MOTION) && (w == 16'sd0);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/velocity_motion_pose_update_unit.sv @@
// Velocity motion pose update: one request in, one pose out.
// A motion request runs a series of multiply and divide steps on the shared serial units; a
// position reset request skips them and goes from idle straight to the update and output register.
// Throughput: one request at a time; the 64-step serial multiplier and divider set the pace.
// Reset: synchronous rst zeroes pose, heading and last timestamp, gains return to 655.
// Depends on vmpu_pkg, vmpu_mul, vmpu_div and vmpu_seq.
`default_nettype none

module velocity_motion_pose_update_unit import vmpu_pkg::*; #(
  parameter int POS_BITS   = POS_BITS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_write,
  input  cfg_idx_t          cfg_index,
  input  logic [GAIN_W-1:0] cfg_data
);

  // drift gains; the user must write them only while the unit is idle, the unit does not enforce it
  logic [GAIN_W-1:0] gain_speed, gain_turn;

  unit_req_t            req;
  unit_ack_t            ack;
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [2*MUL_W-1:0]   mul_p;
  logic [DIV_W-1:0]     div_n, div_d, div_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_speed <= GAIN_RESET;
      gain_turn  <= GAIN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_GAIN_SPEED: gain_speed <= cfg_data;
        CFG_GAIN_TURN:  gain_turn  <= cfg_data;
      endcase
    end
  end

  // Sequencer: holds the pose, walks each motion request through phase terms, the
  // sine/cosine series and the move, and registers the result.
  vmpu_seq #(
    .POS_BITS   (POS_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .gain_speed (gain_speed),
    .gain_turn  (gain_turn),
    .req        (req),
    .ack        (ack),
    .mul_a      (mul_a),
    .mul_b      (mul_b),
    .mul_p      (mul_p),
    .div_n      (div_n),
    .div_d      (div_d),
    .div_q      (div_q)
  );

  // shared serial multiplier: one bit of the multiplier per cycle
  vmpu_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (req.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (ack.mul_done),
    .p     (mul_p)
  );

  // shared serial divider: one quotient bit per cycle
  vmpu_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (req.div_start),
    .n     (div_n),
    .d     (div_d),
    .done  (ack.div_done),
    .q     (div_q)
  );

endmodule

`default_nettype wire

@@ hw/rtl/vmpu_checker.sv @@
// Port-level checks of the pose update unit, attached by bind.
// Depends on vmpu_pkg and velocity_motion_pose_update_unit.
`default_nettype none

module vmpu_checker import vmpu_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in work");

endmodule

bind velocity_motion_pose_update_unit vmpu_checker u_chk (.*);

`default_nettype wire
